>>> hw/rtl/ifq_pkg.sv
`default_nettype none

package ifq_pkg;

    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_BRANCH = 7'h63;

    // One queue slot: instruction word, its address, redirect mark.
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] addr;
        logic        jump;
    } entry_t;

    // What one accepted request does to the held decoder output and the fetch port.
    typedef struct packed {
        logic        pop;
        logic        clr;
        logic        req;
        logic [31:0] addr;
    } step_t;

endpackage

`default_nettype wire

>>> hw/rtl/instruction_fetch_queue_top.sv
// Channel   Handshake                      Payload
// input     in_valid / in_stall            flush, redirect_pc, stall_req,
//                                          fetched_inst, fetched_pc, predict_taken
// output    out_valid / out_stall          issue_valid, issue_inst, issue_addr,
//                                          issue_jump, fetch_req, fetch_addr
//
// One request per clock while in_stall is low; each result passes from the registered read of
// the queue memory and the pipeline stage into the output register, where out_stall can hold it.
// Queue control (head, count, fetch PC, skip flag) updates at the acceptance edge.
// Reset clears control and the held decoder output; queue memory is not cleared.
// in_stall rises only while the pipeline stage and the output register are both full
// and out_stall holds the output.

`default_nettype none

module instruction_fetch_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        flush,
    input  wire logic [31:0] redirect_pc,
    input  wire logic        stall_req,
    input  wire logic [31:0] fetched_inst,
    input  wire logic [31:0] fetched_pc,
    input  wire logic        predict_taken,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             issue_valid,
    output logic [31:0]      issue_inst,
    output logic [31:0]      issue_addr,
    output logic             issue_jump,
    output logic             fetch_req,
    output logic [31:0]      fetch_addr
);

    localparam int IW = $clog2(QUEUE_DEPTH);

    logic            accept;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    ifq_pkg::entry_t wr_data;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    ifq_pkg::entry_t rd_data;
    ifq_pkg::step_t  step;

    assign accept = in_valid && !in_stall;

    ifq_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .flush         (flush),
        .redirect_pc   (redirect_pc),
        .stall_req     (stall_req),
        .fetched_inst  (fetched_inst),
        .fetched_pc    (fetched_pc),
        .predict_taken (predict_taken),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .step          (step)
    );

    ifq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ifq_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .step        (step),
        .rd_data     (rd_data),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .issue_valid (issue_valid),
        .issue_inst  (issue_inst),
        .issue_addr  (issue_addr),
        .issue_jump  (issue_jump),
        .fetch_req   (fetch_req),
        .fetch_addr  (fetch_addr)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ifq_mem.sv
`default_nettype none

module ifq_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire ifq_pkg::entry_t          wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output ifq_pkg::entry_t               rd_data
);

    ifq_pkg::entry_t mem [DEPTH];
    ifq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old contents on a same-edge write to the same slot.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ifq_ctrl.sv
`default_nettype none

module ifq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic                     flush,
    input  wire logic [31:0]              redirect_pc,
    input  wire logic                     stall_req,
    input  wire logic [31:0]              fetched_inst,
    input  wire logic [31:0]              fetched_pc,
    input  wire logic                     predict_taken,
    output logic                          wr_en,
    output logic [$clog2(DEPTH)-1:0]      wr_addr,
    output ifq_pkg::entry_t               wr_data,
    output logic                          rd_en,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    output ifq_pkg::step_t                step
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   pc_reg;
    logic [31:0]   pc_next;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          skip_reg;
    logic          skip_next;

    logic          pop;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] head_pop;
    logic [CW-1:0] count_pop;
    logic [CW:0]   tail_sum;
    logic [IW-1:0] tail;
    logic [6:0]    opcode;
    logic          jump;
    logic [31:0]   imm;
    logic [31:0]   target;
    logic          push;

    assign pop       = !flush && !stall_req && (count_reg != '0);
    assign head_inc  = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_pop  = pop ? head_inc : head_reg;
    assign count_pop = pop ? count_reg - 1'b1 : count_reg;

    // Tail slot after this request's issue; the sum stays below twice the depth.
    assign tail_sum = (CW + 1)'(head_pop) + (CW + 1)'(count_pop);
    assign tail     = (tail_sum >= (CW + 1)'(DEPTH)) ? IW'(tail_sum - (CW + 1)'(DEPTH))
                                                     : IW'(tail_sum);

    assign opcode = fetched_inst[6:0];
    assign jump   = (opcode == ifq_pkg::OP_JAL)
                 || ((opcode == ifq_pkg::OP_BRANCH) && predict_taken);
    assign imm    = (opcode == ifq_pkg::OP_JAL)
        ? {{11{fetched_inst[31]}}, fetched_inst[31], fetched_inst[19:12],
           fetched_inst[20], fetched_inst[30:21], 1'b0}
        : {{19{fetched_inst[31]}}, fetched_inst[31], fetched_inst[7],
           fetched_inst[30:25], fetched_inst[11:8], 1'b0};
    assign target = fetched_pc + imm;

    assign push = !flush && !skip_reg && (fetched_inst != '0)
               && (count_pop != CW'(DEPTH));

    always_comb
    begin
        pc_next    = pc_reg;
        head_next  = head_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        step       = '0;
        if (flush)
        begin
            pc_next    = redirect_pc;
            head_next  = '0;
            count_next = '0;
            skip_next  = 1'b0;
            step.clr   = 1'b1;
        end
        else
        begin
            step.pop   = pop;
            step.clr   = !stall_req && (count_reg == '0);
            head_next  = head_pop;
            count_next = push ? count_pop + 1'b1 : count_pop;
            if (skip_reg)
            begin
                // Drop the word already in flight behind a taken jump.
                skip_next = 1'b0;
            end
            else
            begin
                if (count_reg <= CW'(DEPTH - 3))
                begin
                    step.req  = 1'b1;
                    step.addr = pc_reg;
                    pc_next   = pc_reg + 32'd4;
                end
                if ((fetched_inst != '0) && jump)
                begin
                    pc_next   = target;
                    step.req  = 1'b0;
                    step.addr = '0;
                    skip_next = 1'b1;
                end
            end
        end
    end

    assign wr_en        = accept && push;
    assign wr_addr      = tail;
    assign wr_data.word = fetched_inst;
    assign wr_data.addr = fetched_pc;
    assign wr_data.jump = jump;
    assign rd_en        = accept;
    assign rd_addr      = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pc_reg    <= pc_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && flush |=> (count_reg == '0) && (head_reg == '0) && !skip_reg)
        else $error("flush left queue state behind");

    a_skip_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> !step.req && !wr_en)
        else $error("fetch request or enqueue during skip");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        step.pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/ifq_out.sv
`default_nettype none

module ifq_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire ifq_pkg::step_t  step,
    input  wire ifq_pkg::entry_t rd_data,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 issue_valid,
    output logic [31:0]          issue_inst,
    output logic [31:0]          issue_addr,
    output logic                 issue_jump,
    output logic                 fetch_req,
    output logic [31:0]          fetch_addr
);

    logic           s1_valid_reg;
    ifq_pkg::step_t s1_reg;
    logic           advance;

    logic           out_valid_reg;
    logic           issue_valid_reg;
    logic [31:0]    issue_inst_reg;
    logic [31:0]    issue_addr_reg;
    logic           issue_jump_reg;
    logic           fetch_req_reg;
    logic [31:0]    fetch_addr_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_reg       <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_reg       <= step;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // The held decoder fields carry over from one result to the next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            issue_valid_reg <= 1'b0;
            issue_inst_reg  <= '0;
            issue_addr_reg  <= '0;
            issue_jump_reg  <= 1'b0;
            fetch_req_reg   <= 1'b0;
            fetch_addr_reg  <= '0;
        end
        else if (advance)
        begin
            out_valid_reg  <= 1'b1;
            fetch_req_reg  <= s1_reg.req;
            fetch_addr_reg <= s1_reg.addr;
            if (s1_reg.pop)
            begin
                issue_valid_reg <= 1'b1;
                issue_inst_reg  <= rd_data.word;
                issue_addr_reg  <= rd_data.addr;
                issue_jump_reg  <= rd_data.jump;
            end
            else if (s1_reg.clr)
            begin
                issue_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign issue_valid = issue_valid_reg;
    assign issue_inst  = issue_inst_reg;
    assign issue_addr  = issue_addr_reg;
    assign issue_jump  = issue_jump_reg;
    assign fetch_req   = fetch_req_reg;
    assign fetch_addr  = fetch_addr_reg;

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !s1_valid_reg || advance)
        else $error("request accepted over a pending one");

    a_addr_zero_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !fetch_req_reg |-> fetch_addr_reg == '0)
        else $error("fetch address without request");

    a_pop_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_reg.pop && s1_reg.clr))
        else $error("pop and clear together");

endmodule

`default_nettype wire
